// File: hw/rtl/medp_pkg.sv
// Shared constants, types and the helper function of the MED prediction residual codec.
// Used by the top level and the checker; depends on nothing else.
package medp_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;

  // Width of the dimension registers and of the sample and value fields.
  localparam int DimW    = 12;
  localparam int SampleW = 9;
  localparam int PixW    = 8;

  // Counter widths follow from the largest plane.
  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);

  // Width used for comparing counters against the clamped dimensions.
  localparam int CmpWc = (DimW > ColW + 1) ? DimW : ColW + 1;
  localparam int CmpWr = (DimW > RowW + 1) ? DimW : RowW + 1;

  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;
  localparam int StreamW  = 16;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_e;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  // Median edge detector on three 8-bit neighbours.
  function automatic logic [PixW-1:0] med_predict(input logic [PixW-1:0] a,
                                                   input logic [PixW-1:0] b,
                                                   input logic [PixW-1:0] c);
    logic [PixW-1:0] hi;
    logic [PixW-1:0] lo;
    logic [PixW+1:0] mid;
    hi  = (a > b) ? a : b;
    lo  = (a > b) ? b : a;
    mid = {2'b00, a} + {2'b00, b} - {2'b00, c};
    if (c >= hi) begin
      med_predict = lo;
    end else if (c <= lo) begin
      med_predict = hi;
    end else begin
      med_predict = mid[PixW-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/med_prediction_residual_codec_unit.sv
// Top level of the MED prediction residual codec: stream ports, APB registers,
// counters, prediction stage and output register. Depends on medp_pkg and medp_ram.
//
// The block takes one word per clock cycle without pause, as long as the output side takes
// its words; each sample passes through the registered read of the previous-row line store
// (the prediction stage) and then the output register before it leaves. The line store is a
// single synchronous RAM of MaxWidth bytes with one write and one read port: the sample being
// accepted reads the pixel above it while the sample ahead of it writes its own pixel back,
// and a forwarding register covers the case where both touch the same column (planes one
// column wide). Column and row counters advance as a word is accepted, so the read address
// for the next sample is ready at once. The line store is not cleared after reset; every
// entry the first row reads is written by that row before any later row uses it, so the
// block is ready straight out of reset. Registers sit at byte addresses 0 (direction),
// 4 (plane width) and 8 (plane height) and must only be written while no word is in flight;
// a width or height of zero behaves as one and values above the maximum behave as the
// maximum. tlast on the output marks the last sample of each plane.
module med_prediction_residual_codec_unit
  import medp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // Input stream; tdata: [8:0] sample (signed), [15:9] zero
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [StreamW-1:0]  s_axis_tdata,
  // Output stream; tdata: [8:0] value (signed), [15:9] zero; tlast: plane_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [StreamW-1:0]  m_axis_tdata,
  output logic                m_axis_tlast
);

  // Contents of the prediction stage.
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [ColW-1:0]    col;
    logic               border;
    logic               last;
  } s1_t;

  // Configuration registers.
  dir_e            direction_q;
  logic [DimW-1:0] width_q;
  logic [DimW-1:0] height_q;
  logic            cfg_wr;
  reg_idx_e        cfg_idx;

  // Counters.
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [CmpWc-1:0] w_eff, col_p1;
  logic [CmpWr-1:0] h_eff, row_p1;
  logic             end_row, end_plane;

  // Pipeline.
  logic               accept_in;
  logic               s1_valid_q;
  s1_t                s1_q;
  logic               s1_adv;
  logic [PixW-1:0]    left_q;
  logic [PixW-1:0]    above_left_q;
  logic               fwd_q;
  logic [PixW-1:0]    fwd_pix_q;
  logic [PixW-1:0]    ram_rdata;
  logic [PixW-1:0]    above;
  logic [PixW-1:0]    pred;
  logic [PixW-1:0]    pixel;
  logic [SampleW-1:0] result;
  logic               out_valid_q;
  logic [SampleW-1:0] out_value_q;
  logic               out_last_q;

  // ---------------------------------------------------------------------------------------
  // Configuration port. pready is tied high, so a write lands in the access cycle.
  // ---------------------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DIR_ENCODE;
      width_q     <= DimW'(640);
      height_q    <= DimW'(480);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DIRECTION: direction_q <= dir_e'(pwdata[0]);
        REG_WIDTH:     width_q     <= pwdata[DimW-1:0];
        REG_HEIGHT:    height_q    <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_DIRECTION: prdata = ApbDataW'(direction_q);
      REG_WIDTH:     prdata = ApbDataW'(width_q);
      REG_HEIGHT:    prdata = ApbDataW'(height_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Handshakes. The prediction stage moves on whenever the output register is free or is
  // being emptied, and a new word enters as the stage empties.
  // ---------------------------------------------------------------------------------------
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept_in     = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------------------
  // Counters, advanced at acceptance so that the next read address is known at once.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    if (width_q == '0) begin
      w_eff = CmpWc'(1);
    end else if (CmpWc'(width_q) > CmpWc'(MaxWidth)) begin
      w_eff = CmpWc'(MaxWidth);
    end else begin
      w_eff = CmpWc'(width_q);
    end
    if (height_q == '0) begin
      h_eff = CmpWr'(1);
    end else if (CmpWr'(height_q) > CmpWr'(MaxHeight)) begin
      h_eff = CmpWr'(MaxHeight);
    end else begin
      h_eff = CmpWr'(height_q);
    end
    col_p1    = CmpWc'(col_q) + CmpWc'(1);
    row_p1    = CmpWr'(row_q) + CmpWr'(1);
    end_row   = (col_p1 >= w_eff);
    end_plane = end_row && (row_p1 >= h_eff);
    if (end_row) begin
      col_d = '0;
      row_d = end_plane ? '0 : row_p1[RowW-1:0];
    end else begin
      col_d = col_p1[ColW-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_in) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Line store: read at acceptance, written back as the prediction stage moves on.
  // ---------------------------------------------------------------------------------------
  medp_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_q.col),
    .wdata_i (pixel),
    .re_i    (accept_in),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------------------
  // Prediction stage.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept_in) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // The write of the stage ahead lands in the same cycle as this read, so its pixel is
  // captured here when the columns match.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_q.sample <= s_axis_tdata[SampleW-1:0];
      s1_q.col    <= col_q;
      s1_q.border <= (row_q == '0) || (col_q == '0);
      s1_q.last   <= end_plane;
      fwd_q       <= s1_adv && (s1_q.col == col_q);
      fwd_pix_q   <= pixel;
    end
  end

  always_comb begin
    above = fwd_q ? fwd_pix_q : ram_rdata;
    pred  = med_predict(left_q, above, above_left_q);
    if (s1_q.border) begin
      pixel  = s1_q.sample[PixW-1:0];
      result = {1'b0, pixel};
    end else if (direction_q == DIR_ENCODE) begin
      pixel  = s1_q.sample[PixW-1:0];
      result = {1'b0, pixel} - {1'b0, pred};
    end else begin
      pixel  = s1_q.sample[PixW-1:0] + pred;
      result = {1'b0, pixel};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      above_left_q <= '0;
    end else if (s1_adv) begin
      left_q       <= pixel;
      above_left_q <= above;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q <= result;
      out_last_q  <= s1_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = StreamW'(out_value_q);
  assign m_axis_tlast  = out_last_q;

endmodule

// File: hw/rtl/medp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; used for the previous-row line store.
module medp_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/medp_checker.sv
// Port-level checker for the MED prediction residual codec, with its bind statement.
// Depends on medp_pkg; attaches to med_prediction_residual_codec_unit.
module medp_checker
  import medp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [ApbAddrW-1:0] paddr,
  input logic [ApbDataW-1:0] pwdata,
  input logic [ApbDataW-1:0] prdata,
  input logic                pready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [StreamW-1:0]  m_axis_tdata,
  input logic                m_axis_tlast
);

  // A stalled output word keeps its valid.
  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // A stalled output word keeps its payload.
  a_out_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Values are nine-bit results padded with zeros up to the byte boundary.
  a_out_padding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[StreamW-1:SampleW] == '0)
    else $error("output padding bits not zero");

  // A direction write is read back in the following cycle.
  a_dir_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr == ApbAddrW'(0)) ##1 (paddr == ApbAddrW'(0))
    |-> prdata == ApbDataW'($past(pwdata[0])))
    else $error("direction register read-back mismatch");

endmodule

bind med_prediction_residual_codec_unit medp_checker u_medp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
